// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the command line parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define SCL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define SCL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/scl_pkg.sv
// Types, constants and default parameters of the serial command line parser.
package scl_pkg;

    localparam int NAME_CHARS_DEF  = 8;
    localparam int MAX_PARAMS_DEF  = 8;
    localparam int FIELD_CHARS_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic CMD_DATA    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } scl_phase_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_STATUS,
        SEQ_PARAM
    } scl_seq_state_t;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } scl_cmd_t;

    typedef struct packed {
        logic               done_res;
        logic               error;
        logic [63:0]        name_text;
        logic [3:0]         param_count;
        logic               is_parameter;
        logic [2:0]         param_index;
        logic signed [31:0] param_value;
        logic               last_result;
    } scl_res_t;

    typedef struct packed {
        logic        error;
        logic [63:0] name_text;
        logic [3:0]  param_count;
    } scl_stat_t;

endpackage

// File: rtl/scl_parser.sv
// Character parser: name capture, field counting and decimal number accumulation.
module scl_parser #(
    parameter int NAME_CHARS  = scl_pkg::NAME_CHARS_DEF,
    parameter int MAX_PARAMS  = scl_pkg::MAX_PARAMS_DEF,
    parameter int FIELD_CHARS = scl_pkg::FIELD_CHARS_DEF,
    parameter int VALUE_WIDTH = scl_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              accept,
    input  scl_pkg::scl_cmd_t                                 cmd,
    output logic                                              item_done,
    output logic                                              wr_en,
    output logic [((MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1)-1:0] wr_addr,
    output logic [VALUE_WIDTH-1:0]                            wr_data,
    output scl_pkg::scl_stat_t                                stat
);

    localparam int CNT_W  = $clog2(MAX_PARAMS + 1);
    localparam int ADDR_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int FC_MAX = (FIELD_CHARS > NAME_CHARS) ? FIELD_CHARS : NAME_CHARS;
    localparam int FC_W   = $clog2(FC_MAX + 2);

    logic                    err_reg, err_next;
    logic                    skip_reg, skip_next;
    logic                    inparm_reg, inparm_next;
    logic [FC_W-1:0]         fc_reg, fc_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0]  acc_reg, acc_next;
    scl_pkg::scl_phase_t     phase_reg, phase_next;
    logic                    neg_reg, neg_next;
    logic [7:0]              name_reg [NAME_CHARS];

    logic [7:0]              c;
    logic                    is_blank, is_lead_ws, is_sign, is_digit, is_comma, is_end;
    logic [FC_W-1:0]         fc_inc;
    logic [3:0]              digit;
    logic [VALUE_WIDTH-1:0]  acc_x10;
    logic                    name_we, name_clr;

    assign c          = cmd.data_byte;
    assign is_blank   = (c == scl_pkg::CH_SPACE) || (c == scl_pkg::CH_TAB);
    assign is_lead_ws = c inside {scl_pkg::CH_TAB, scl_pkg::CH_VT, scl_pkg::CH_FF,
                                  scl_pkg::CH_SPACE};
    assign is_sign    = c inside {scl_pkg::CH_PLUS, scl_pkg::CH_MINUS};
    assign is_digit   = c inside {[scl_pkg::CH_ZERO:scl_pkg::CH_NINE]};
    assign is_comma   = (c == scl_pkg::CH_COMMA);
    assign is_end     = c inside {scl_pkg::CH_LF, scl_pkg::CH_CR, scl_pkg::CH_SEMI};
    assign fc_inc     = fc_reg + 1'b1;
    assign digit      = 4'(c - scl_pkg::CH_ZERO);
    assign acc_x10    = (acc_reg << 3) + (acc_reg << 1)
                      + {{(VALUE_WIDTH - 4){1'b0}}, digit};

    always_comb
    begin
        err_next    = err_reg;
        skip_next   = skip_reg;
        inparm_next = inparm_reg;
        fc_next     = fc_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        name_we     = 1'b0;
        name_clr    = 1'b0;
        wr_en       = 1'b0;
        item_done   = 1'b0;
        if (accept)
        begin
            if (cmd.command == scl_pkg::CMD_RESTART)
            begin
                err_next    = 1'b0;
                skip_next   = 1'b1;
                inparm_next = 1'b0;
                fc_next     = '0;
                cnt_next    = '0;
                acc_next    = '0;
                phase_next  = scl_pkg::PH_LEAD;
                neg_next    = 1'b0;
                name_clr    = 1'b1;
            end
            else if (!err_reg && !(skip_reg && is_blank))
            begin
                skip_next = is_blank;
                if (is_comma || is_end)
                begin
                    if (inparm_reg && (cnt_reg >= CNT_W'(MAX_PARAMS)))
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        if (inparm_reg)
                        begin
                            wr_en    = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        fc_next     = '0;
                        acc_next    = '0;
                        phase_next  = scl_pkg::PH_LEAD;
                        neg_next    = 1'b0;
                        inparm_next = 1'b1;
                        skip_next   = 1'b1;
                        item_done   = is_end;
                    end
                end
                else if (!inparm_reg)
                begin
                    name_we = (fc_reg < FC_W'(NAME_CHARS));
                    fc_next = fc_inc;
                    if (fc_inc > FC_W'(NAME_CHARS))
                    begin
                        err_next = 1'b1;
                    end
                end
                else
                begin
                    fc_next = fc_inc;
                    if (fc_inc > FC_W'(FIELD_CHARS))
                    begin
                        err_next = 1'b1;
                    end
                    else if (phase_reg != scl_pkg::PH_DONE)
                    begin
                        if ((phase_reg == scl_pkg::PH_LEAD) && is_lead_ws)
                        begin
                            phase_next = phase_reg;
                        end
                        else if ((phase_reg == scl_pkg::PH_LEAD) && is_sign)
                        begin
                            neg_next   = (c == scl_pkg::CH_MINUS);
                            phase_next = scl_pkg::PH_SIGN;
                        end
                        else if (is_digit)
                        begin
                            acc_next   = acc_x10;
                            phase_next = scl_pkg::PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = scl_pkg::PH_DONE;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg    <= 1'b0;
            skip_reg   <= 1'b1;
            inparm_reg <= 1'b0;
            fc_reg     <= '0;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            phase_reg  <= scl_pkg::PH_LEAD;
            neg_reg    <= 1'b0;
        end
        else
        begin
            err_reg    <= err_next;
            skip_reg   <= skip_next;
            inparm_reg <= inparm_next;
            fc_reg     <= fc_next;
            cnt_reg    <= cnt_next;
            acc_reg    <= acc_next;
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NAME_CHARS; i++)
            begin
                name_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NAME_CHARS; i++)
            begin
                if (name_clr)
                begin
                    name_reg[i] <= '0;
                end
                else if (name_we && (fc_reg == FC_W'(i)))
                begin
                    name_reg[i] <= c;
                end
            end
        end
    end

    always_comb
    begin
        stat.name_text = '0;
        for (int i = 0; i < NAME_CHARS; i++)
        begin
            stat.name_text[8*i +: 8] = name_reg[i];
        end
        stat.error       = err_reg;
        stat.param_count = 4'(cnt_reg);
    end

    assign wr_addr = cnt_reg[ADDR_W-1:0];
    assign wr_data = neg_reg ? (VALUE_WIDTH'(0) - acc_reg) : acc_reg;

endmodule

// File: rtl/scl_result_seq.sv
// Parameter memory and result sequencer that issues the status and parameter words.
module scl_result_seq #(
    parameter int MAX_PARAMS  = scl_pkg::MAX_PARAMS_DEF,
    parameter int VALUE_WIDTH = scl_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              accept,
    input  logic                                              item_done,
    input  scl_pkg::scl_stat_t                                stat,
    input  logic                                              wr_en,
    input  logic [((MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1)-1:0] wr_addr,
    input  logic [VALUE_WIDTH-1:0]                            wr_data,
    output logic                                              take,
    input  logic                                              res_stall,
    output logic                                              res_valid,
    output scl_pkg::scl_res_t                                 res_word
);

    localparam int ADDR_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

    logic [VALUE_WIDTH-1:0]   mem [MAX_PARAMS];
    logic [VALUE_WIDTH-1:0]   rd_data_reg;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;

    scl_pkg::scl_seq_state_t  state_reg, state_next;
    logic [ADDR_W-1:0]        pidx_reg, pidx_next;
    logic                     done_reg, done_next;
    logic                     valid_reg, valid_next;
    scl_pkg::scl_res_t        res_reg, res_next;

    logic                     out_free, has_params, last_param;
    logic                     load_status, load_param;
    logic [63:0]              rd_wide;

    assign out_free    = !valid_reg || !res_stall;
    assign has_params  = done_reg && (stat.param_count != 4'd0);
    assign last_param  = ((4'(pidx_reg) + 4'd1) == stat.param_count);
    assign load_status = (state_reg == scl_pkg::SEQ_STATUS) && out_free;
    assign load_param  = (state_reg == scl_pkg::SEQ_PARAM) && out_free;
    assign rd_en       = (load_status && has_params) || (load_param && !last_param);
    assign rd_addr     = load_status ? '0 : (pidx_reg + 1'b1);
    assign rd_wide     = 64'(rd_data_reg);
    assign take        = (state_reg == scl_pkg::SEQ_IDLE) || (load_status && !has_params);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pidx_next  = pidx_reg;
        done_next  = done_reg;
        valid_next = valid_reg && res_stall;
        res_next   = res_reg;
        if (accept)
        begin
            done_next = item_done;
        end
        case (state_reg)
            scl_pkg::SEQ_IDLE:
            begin
                if (accept)
                begin
                    state_next = scl_pkg::SEQ_STATUS;
                end
            end
            scl_pkg::SEQ_STATUS:
            begin
                if (out_free)
                begin
                    if (has_params)
                    begin
                        state_next = scl_pkg::SEQ_PARAM;
                    end
                    else if (accept)
                    begin
                        state_next = scl_pkg::SEQ_STATUS;
                    end
                    else
                    begin
                        state_next = scl_pkg::SEQ_IDLE;
                    end
                end
            end
            scl_pkg::SEQ_PARAM:
            begin
                if (out_free && last_param)
                begin
                    state_next = scl_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = scl_pkg::SEQ_IDLE;
            end
        endcase
        if (load_status)
        begin
            pidx_next             = '0;
            valid_next            = 1'b1;
            res_next.done_res     = done_reg;
            res_next.error        = stat.error;
            res_next.name_text    = stat.name_text;
            res_next.param_count  = stat.param_count;
            res_next.is_parameter = 1'b0;
            res_next.param_index  = '0;
            res_next.param_value  = '0;
            res_next.last_result  = !has_params;
        end
        else if (load_param)
        begin
            if (!last_param)
            begin
                pidx_next = pidx_reg + 1'b1;
            end
            valid_next            = 1'b1;
            res_next.done_res     = done_reg;
            res_next.error        = stat.error;
            res_next.name_text    = stat.name_text;
            res_next.param_count  = stat.param_count;
            res_next.is_parameter = 1'b1;
            res_next.param_index  = 3'(pidx_reg);
            res_next.param_value  = signed'(rd_wide[31:0]);
            res_next.last_result  = last_param;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scl_pkg::SEQ_IDLE;
            pidx_reg  <= '0;
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pidx_reg  <= pidx_next;
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = valid_reg;
    assign res_word  = res_reg;

endmodule

// File: rtl/serial_command_line_parser.sv
// Top level of the serial command line parser.
// The status word of a byte is loaded from the registered parser state into the result register.
// Input rate: one byte per cycle while the result side does not stall; a command-ending byte
// with stored parameters holds off the next byte while the status word and one word per
// parameter are issued.
// Reset: rst_n clears the parser and sequencer control state asynchronously; a restart
// word clears the parser state.
module serial_command_line_parser #(
    parameter int NAME_CHARS  = scl_pkg::NAME_CHARS_DEF,
    parameter int MAX_PARAMS  = scl_pkg::MAX_PARAMS_DEF,
    parameter int FIELD_CHARS = scl_pkg::FIELD_CHARS_DEF,
    parameter int VALUE_WIDTH = scl_pkg::VALUE_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  scl_pkg::scl_cmd_t cmd_word,
    output logic              res_valid,
    input  logic              res_stall,
    output scl_pkg::scl_res_t res_word
);

    localparam int ADDR_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

    logic                   take;
    logic                   accept;
    logic                   item_done;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    scl_pkg::scl_stat_t     stat;

    assign accept    = cmd_valid && take;
    assign cmd_stall = !take;

    scl_parser #(
        .NAME_CHARS  (NAME_CHARS),
        .MAX_PARAMS  (MAX_PARAMS),
        .FIELD_CHARS (FIELD_CHARS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd_word),
        .item_done (item_done),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .stat      (stat)
    );

    scl_result_seq #(
        .MAX_PARAMS  (MAX_PARAMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_result_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item_done (item_done),
        .stat      (stat),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .take      (take),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res_word  (res_word)
    );

endmodule

// File: rtl/scl_checker.sv
// Port-level checker for the serial command line parser and its bind statement.
`include "assert_macros.svh"

module scl_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_stall,
    input scl_pkg::scl_cmd_t cmd_word,
    input logic              res_valid,
    input logic              res_stall,
    input scl_pkg::scl_res_t res_word
);

    `SCL_ASSERT_ALWAYS(a_no_word_in_reset, !rst_n |-> !res_valid, "result word valid in reset")
    `SCL_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res_word), "stalled result word changed")
    `SCL_ASSERT(a_status_clean, res_valid && !res_word.is_parameter |-> res_word.param_index == 3'd0 && res_word.param_value == 32'sd0, "status word carries parameter data")
    `SCL_ASSERT(a_param_in_range, res_valid && res_word.is_parameter |-> res_word.done_res && ({1'b0, res_word.param_index} < res_word.param_count), "parameter word out of range")
    `SCL_ASSERT(a_burst_blocks_input, res_valid && !res_word.last_result |-> cmd_stall, "input taken during a result burst")

endmodule

bind serial_command_line_parser scl_checker u_scl_checker (.*);
